/* hw/rtl/mtmc_pkg.sv */
// Shared constants, codes and controller/datapath bundles for the tempo map converter.
package mtmc_pkg;

    localparam int TEMPO_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TEMPO_ENTRIES);
    localparam int CNT_W         = $clog2(TEMPO_ENTRIES + 1);

    localparam int TICK_W   = 32;
    localparam int TIME_W   = 56;
    localparam int TEMPO_W  = 24;
    localparam int TPQ_W    = 15;
    localparam int ENTRY_W  = TICK_W + TIME_W + TEMPO_W;

    localparam int DIV_NUM_W = 65;
    localparam int DIV_DEN_W = 24;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [APB_AW-1:0]  ADDR_TPQ      = '0;
    localparam logic [TPQ_W-1:0]   TPQ_RESET     = 15'd480;
    localparam logic [TEMPO_W-1:0] PPQ_NORM      = 24'd480;
    localparam logic [TEMPO_W-1:0] DEFAULT_TEMPO = 24'd500000;

    typedef enum logic [1:0] {
        OP_APPEND    = 2'd0,
        OP_TICK2TIME = 2'd1,
        OP_TIME2TICK = 2'd2,
        OP_CLEAR     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_ORDER = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        DIV_SCALE = 2'd0,
        DIV_TIME  = 2'd1,
        DIV_TICK  = 2'd2
    } div_sel_t;

    // controller to datapath
    typedef struct packed {
        logic     capture;
        logic     rd_last;
        logic     scan_start;
        logic     div_start;
        div_sel_t div_sel;
        logic     mul;
        logic     write_entry;
        logic     clear;
        logic     status_wr;
        status_t  status_val;
        logic     finish;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        op_t  op;
        logic full;
        logic order_bad;
        logic rd_done;
        logic div_done;
        logic out_busy;
    } ctl_sts_t;

endpackage

/* hw/rtl/mtmc_if.sv */
// Word channels of the tempo map converter: request in, answer out.
interface mtmc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] tick;
    logic [23:0] tempo_us;
    logic [55:0] time_us;

    modport source (output valid, opcode, tick, tempo_us, time_us, input ready);
    modport sink   (input valid, opcode, tick, tempo_us, time_us, output ready);
endinterface

interface mtmc_out_if;
    logic        valid;
    logic        ready;
    logic [55:0] time_out_us;
    logic [31:0] tick_out;
    logic [1:0]  status;

    modport source (output valid, time_out_us, tick_out, status, input ready);
    modport sink   (input valid, time_out_us, tick_out, status, output ready);
endinterface

/* hw/rtl/mtmc_ram.sv */
// Generic single-port-write, registered-read RAM.
module mtmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/mtmc_div.sv */
// Restoring divider, one quotient bit per cycle.
module mtmc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [mtmc_pkg::DIV_NUM_W-1:0] num,
    input  logic [mtmc_pkg::DIV_DEN_W-1:0] den,
    output logic                          done,
    output logic [mtmc_pkg::DIV_NUM_W-1:0] quo
);
    import mtmc_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [DIV_NUM_W-1:0] q_reg, q_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W:0]   shifted;
    logic                 ge;

    // one shift-subtract step
    always_comb
    begin
        shifted   = {rem_reg, q_reg[DIV_NUM_W-1]};
        ge        = shifted >= {1'b0, den_reg};
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        q_next    = q_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            cnt_next = DIV_CNT_W'(DIV_NUM_W);
            q_next   = num;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DIV_CNT_W'(1));
            q_next    = {q_reg[DIV_NUM_W-2:0], ge};
            rem_next  = ge ? DIV_DEN_W'(shifted - {1'b0, den_reg}) : shifted[DIV_DEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

/* hw/rtl/mtmc_datapath.sv */
// Tempo table storage, search, arithmetic and result register.
module mtmc_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mtmc_pkg::ctl_cmd_t            cmd,
    output mtmc_pkg::ctl_sts_t            sts,
    input  logic [1:0]                    opcode,
    input  logic [31:0]                   tick,
    input  logic [23:0]                   tempo_us,
    input  logic [55:0]                   time_us,
    input  logic [mtmc_pkg::TPQ_W-1:0]    tpq,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [55:0]                   time_out_us,
    output logic [31:0]                   tick_out,
    output logic [1:0]                    status
);
    import mtmc_pkg::*;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // widths of the divide-by-480 path: five bits dropped, then a /15 fold
    localparam int Y_W    = TIME_W - 5;
    localparam int FOLD_W = Y_W + 1;
    localparam int Q15_W  = FOLD_W - 4;

    // captured word
    op_t                op_reg;
    logic [TICK_W-1:0]  tick_reg;
    logic [TEMPO_W-1:0] tempo_reg;
    logic [TIME_W-1:0]  time_reg;

    // table fill and search
    logic [CNT_W-1:0]   count_reg;
    logic               scan_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               rd_vld_reg, rd_zero_reg, rd_last_reg, force_reg;
    logic [TICK_W-1:0]  seg_tick_reg;
    logic [TIME_W-1:0]  seg_time_reg;
    logic [TEMPO_W-1:0] seg_tempo_reg;

    // arithmetic
    logic [TICK_W-1:0]  st_reg;
    logic [TIME_W-1:0]  prod_reg;
    status_t            status_reg;

    // divide by 480 pipeline
    logic [FOLD_W-1:0]  fold1_reg, fold2_reg;
    logic [TIME_W-1:0]  tdiv_reg;
    logic               tdiv_v1_reg, tdiv_v2_reg, tdiv_v3_reg;

    // result register
    logic               out_valid_reg;
    logic [TIME_W-1:0]  time_out_reg;
    logic [TICK_W-1:0]  tick_out_reg;
    status_t            status_out_reg;

    logic               issue, issue_last, issue_zero;
    logic [IDX_W-1:0]   raddr;
    logic [ENTRY_W-1:0] rdata, wdata;
    logic [TICK_W-1:0]  e_tick;
    logic [TIME_W-1:0]  e_time;
    logic [TEMPO_W-1:0] e_tempo;
    logic               match;
    logic [DIV_NUM_W-1:0] div_num, quo;
    logic [DIV_DEN_W-1:0] div_den;
    logic               div_done;
    logic               div_go, tdiv_start;
    logic [Y_W-1:0]     y480;
    logic [FOLD_W-1:0]  fold_a, fold_1, fold_c, fold_2;
    logic [Q15_W-1:0]   q15_est, q15;
    logic [5:0]         r15;
    logic [TIME_W-1:0]  dt;
    logic [TICK_W-1:0]  st, mul_d, tick_calc;
    logic [TIME_W-1:0]  time_calc;
    logic [TIME_W:0]    time_sum;
    logic [TICK_W:0]    tick_sum;
    logic [TEMPO_W-1:0] tempo_store;

    // read issue: one read for the last entry, or a walk over the table
    always_comb
    begin
        issue      = cmd.rd_last || scan_reg;
        raddr      = cmd.rd_last ? IDX_W'(count_reg - 1'b1) : idx_reg;
        issue_last = cmd.rd_last || (CNT_W'(idx_reg) == count_reg - 1'b1);
        issue_zero = (raddr == '0);
    end

    mtmc_ram #(.WIDTH(ENTRY_W), .DEPTH(TEMPO_ENTRIES)) u_table (
        .clk   (clk),
        .we    (cmd.write_entry),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // entry 0 is fixed and never stored
    always_comb
    begin
        e_tick  = rd_zero_reg ? '0 : rdata[ENTRY_W-1 -: TICK_W];
        e_time  = rd_zero_reg ? '0 : rdata[TEMPO_W +: TIME_W];
        e_tempo = rd_zero_reg ? DEFAULT_TEMPO : rdata[TEMPO_W-1:0];
        match   = force_reg ||
                  ((op_reg == OP_TICK2TIME) ? (e_tick <= tick_reg) : (e_time <= time_reg));
    end

    // divider operands
    always_comb
    begin
        dt         = time_reg - seg_time_reg;
        tdiv_start = cmd.div_start && (cmd.div_sel == DIV_TIME);
        div_go     = cmd.div_start && (cmd.div_sel != DIV_TIME);
        case (cmd.div_sel)
            DIV_SCALE:
            begin
                div_num = (DIV_NUM_W'(tick_reg) << 9) - (DIV_NUM_W'(tick_reg) << 5);
                div_den = (tpq == '0) ? DIV_DEN_W'(1) : DIV_DEN_W'(tpq);
            end
            DIV_TICK:
            begin
                div_num = (DIV_NUM_W'(dt) << 9) - (DIV_NUM_W'(dt) << 5);
                div_den = seg_tempo_reg;
            end
            default:
            begin
                div_num = '0;
                div_den = DIV_DEN_W'(1);
            end
        endcase
    end

    mtmc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_go),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (quo)
    );

    // product / 480: drop five bits (/32), then y/15 as y*(1/16)(1+2^-4)(1+2^-8)(1+2^-16)(1+2^-32);
    // the estimate can be up to two low, and the remainder mod 64 fixes it
    always_comb
    begin
        y480    = prod_reg[TIME_W-1:5];
        fold_a  = FOLD_W'(y480) + FOLD_W'(y480 >> 4);
        fold_1  = fold_a + (fold_a >> 8);
        fold_c  = fold1_reg + (fold1_reg >> 16);
        fold_2  = fold_c + (fold_c >> 32);
        q15_est = fold2_reg[FOLD_W-1:4];
        r15     = y480[5:0] - {q15_est[1:0], 4'b0000} + q15_est[5:0];
        if (r15 >= 6'd30)
        begin
            q15 = q15_est + Q15_W'(2);
        end
        else if (r15 >= 6'd15)
        begin
            q15 = q15_est + Q15_W'(1);
        end
        else
        begin
            q15 = q15_est;
        end
    end

    // saturated results built from the quotients
    always_comb
    begin
        st          = (quo[DIV_NUM_W-1:TICK_W] != '0) ? TICK_MAX : quo[TICK_W-1:0];
        mul_d       = (op_reg == OP_APPEND) ? (st - seg_tick_reg) : (tick_reg - seg_tick_reg);
        time_sum    = {1'b0, seg_time_reg} + {1'b0, tdiv_reg};
        time_calc   = time_sum[TIME_W] ? TIME_MAX : time_sum[TIME_W-1:0];
        tick_sum    = {1'b0, quo[TICK_W-1:0]} + {1'b0, seg_tick_reg};
        tick_calc   = ((quo[DIV_NUM_W-1:TICK_W] != '0) || tick_sum[TICK_W]) ?
                      TICK_MAX : tick_sum[TICK_W-1:0];
        tempo_store = (tempo_reg == '0) ? TEMPO_W'(1) : tempo_reg;
        wdata       = {st_reg, time_calc, tempo_store};
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= CNT_W'(1);
            scan_reg      <= 1'b0;
            idx_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            tdiv_v1_reg   <= 1'b0;
            tdiv_v2_reg   <= 1'b0;
            tdiv_v3_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                count_reg <= CNT_W'(1);
            end
            else if (cmd.write_entry)
            begin
                count_reg <= count_reg + 1'b1;
            end

            if (cmd.scan_start)
            begin
                scan_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (scan_reg)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (issue_last)
                begin
                    scan_reg <= 1'b0;
                end
            end
            rd_vld_reg <= issue;

            tdiv_v1_reg <= tdiv_start;
            tdiv_v2_reg <= tdiv_v1_reg;
            tdiv_v3_reg <= tdiv_v2_reg;

            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= op_t'(opcode);
            tick_reg   <= tick;
            tempo_reg  <= tempo_us;
            time_reg   <= time_us;
            status_reg <= ST_OK;
        end
        else if (cmd.status_wr)
        begin
            status_reg <= cmd.status_val;
        end

        rd_zero_reg <= issue_zero;
        rd_last_reg <= issue_last;
        force_reg   <= cmd.rd_last;
        if (rd_vld_reg && match)
        begin
            seg_tick_reg  <= e_tick;
            seg_time_reg  <= e_time;
            seg_tempo_reg <= e_tempo;
        end

        if (cmd.mul)
        begin
            st_reg   <= st;
            prod_reg <= TIME_W'(mul_d) * TIME_W'(seg_tempo_reg);
        end

        if (tdiv_start)
        begin
            fold1_reg <= fold_1;
        end
        if (tdiv_v1_reg)
        begin
            fold2_reg <= fold_2;
        end
        if (tdiv_v2_reg)
        begin
            tdiv_reg <= TIME_W'(q15);
        end

        if (cmd.finish)
        begin
            time_out_reg   <= (op_reg == OP_TICK2TIME) ? time_calc : '0;
            tick_out_reg   <= (op_reg == OP_TIME2TICK) ? tick_calc : '0;
            status_out_reg <= status_reg;
        end
    end

    always_comb
    begin
        sts.op        = op_reg;
        sts.full      = (count_reg == CNT_W'(TEMPO_ENTRIES));
        sts.order_bad = (st < seg_tick_reg);
        sts.rd_done   = rd_vld_reg && rd_last_reg;
        sts.div_done  = div_done || tdiv_v3_reg;
        sts.out_busy  = out_valid_reg && !out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign time_out_us = time_out_reg;
    assign tick_out    = tick_out_reg;
    assign status      = status_out_reg;

endmodule

/* hw/rtl/mtmc_ctrl.sv */
// Sequencer that steps the datapath through each operation.
module mtmc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mtmc_pkg::ctl_sts_t sts,
    output mtmc_pkg::ctl_cmd_t cmd
);
    import mtmc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_APP_DIV,
        S_APP_CHK,
        S_SCAN,
        S_SEG,
        S_MUL,
        S_TDIV,
        S_KDIV,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel    = DIV_SCALE;
        cmd.status_val = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (sts.op)
                    OP_APPEND:
                    begin
                        if (sts.full)
                        begin
                            cmd.status_wr  = 1'b1;
                            cmd.status_val = ST_FULL;
                            state_next     = S_FINISH;
                        end
                        else
                        begin
                            cmd.div_start = 1'b1;
                            cmd.rd_last   = 1'b1;
                            state_next    = S_APP_DIV;
                        end
                    end
                    OP_TICK2TIME, OP_TIME2TICK:
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                    default:
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_APP_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_APP_CHK;
                end
            end
            S_APP_CHK:
            begin
                if (sts.order_bad)
                begin
                    cmd.status_wr  = 1'b1;
                    cmd.status_val = ST_ORDER;
                    state_next     = S_FINISH;
                end
                else
                begin
                    cmd.mul    = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_SCAN:
            begin
                if (sts.rd_done)
                begin
                    state_next = S_SEG;
                end
            end
            S_SEG:
            begin
                if (sts.op == OP_TICK2TIME)
                begin
                    cmd.mul    = 1'b1;
                    state_next = S_MUL;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_TICK;
                    state_next    = S_KDIV;
                end
            end
            S_MUL:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_TIME;
                state_next    = S_TDIV;
            end
            S_TDIV:
            begin
                if (sts.div_done)
                begin
                    cmd.write_entry = (sts.op == OP_APPEND);
                    state_next      = S_FINISH;
                end
            end
            S_KDIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

/* hw/rtl/midi_tempo_map_converter.sv */
// Top level of the MIDI tempo map converter: channels, register port and assertions.
// Handles one word at a time; the answer sits in an output register so the next
// word is taken as soon as the sequencer is back in idle, and a finished word waits
// in the sequencer while the previous answer is still held. Work per word, with N the
// number of table entries held (1 to 64): clear and append to a full table need no
// arithmetic; append takes one pass of the shared 65-step divider (rescale) plus the
// divide by 480 (start time); tick-to-time takes N table reads through the RAM port
// plus the divide by 480; time-to-tick takes the N-read table walk plus one divider
// pass. Appends must come in nondecreasing tick order; one that does not, or one to
// a full table, is dropped and flagged in status. No clearing pass is needed after
// reset.
module midi_tempo_map_converter (
    input  logic                          clk,
    input  logic                          rst_n,
    mtmc_in_if.sink                       in_ch,
    mtmc_out_if.source                    out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mtmc_pkg::APB_AW-1:0]   paddr,
    input  logic [mtmc_pkg::APB_DW-1:0]   pwdata,
    output logic [mtmc_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import mtmc_pkg::*;

    logic [TPQ_W-1:0] tpq_reg;
    ctl_cmd_t         cmd;
    ctl_sts_t         sts;

    // resolution register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpq_reg <= TPQ_RESET;
        end
        else if (psel && penable && pwrite && (paddr == ADDR_TPQ))
        begin
            tpq_reg <= pwdata[TPQ_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_TPQ) ? APB_DW'(tpq_reg) : '0;

    mtmc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mtmc_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .opcode      (in_ch.opcode),
        .tick        (in_ch.tick),
        .tempo_us    (in_ch.tempo_us),
        .time_us     (in_ch.time_us),
        .tpq         (tpq_reg),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .time_out_us (out_ch.time_out_us),
        .tick_out    (out_ch.tick_out),
        .status      (out_ch.status)
    );

`ifndef NO_ASSERTIONS
    // one word in flight: ready drops right after a word is taken
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("word taken while another is in flight");

    // a waiting answer stays put until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.time_out_us) &&
        $stable(out_ch.tick_out) && $stable(out_ch.status))
        else $error("answer changed while waiting");

    // never store past the end of the table
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_entry |-> !sts.full)
        else $error("write to full table");

    // the result register is only loaded when free
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !sts.out_busy)
        else $error("answer overwritten");
`endif

endmodule

/* tb/midi_tempo_map_converter_tb.sv */
// Self-checking testbench for the MIDI tempo map converter: directed and random words, APB setup.
module midi_tempo_map_converter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mtmc_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int LONG_HOLD      = 500;

    typedef struct packed {
        op_t                op;
        logic [TICK_W-1:0]  tick;
        logic [TEMPO_W-1:0] tempo;
        logic [TIME_W-1:0]  time_v;
    } tempo_req_t;

    typedef struct packed {
        logic [TIME_W-1:0] time_out;
        logic [TICK_W-1:0] tick_out;
        logic [1:0]        status;
    } tempo_ans_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    mtmc_in_if  in_ch ();
    mtmc_out_if out_ch ();

    midi_tempo_map_converter DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock, 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // shadow of the tempo table and the resolution register
    logic [TICK_W-1:0]  tbl_tick  [TEMPO_ENTRIES];
    logic [TIME_W-1:0]  tbl_time  [TEMPO_ENTRIES];
    logic [TEMPO_W-1:0] tbl_tempo [TEMPO_ENTRIES];
    int unsigned        tbl_count;
    logic [TPQ_W-1:0]   shadow_tpq;

    tempo_ans_t answer_q [$];
    int unsigned mismatches;
    int unsigned words_sent;
    int unsigned answers_seen;
    int unsigned full_seen, order_seen;
    logic [31:0] file_pos;
    bit long_hold_req;

    function automatic void table_reset();
        for (int i = 0; i < TEMPO_ENTRIES; i++)
        begin
            tbl_tick[i]  = '0;
            tbl_time[i]  = '0;
            tbl_tempo[i] = '0;
        end
        tbl_tempo[0] = DEFAULT_TEMPO;
        tbl_count    = 1;
    endfunction

    // start time of a tick inside segment seg, saturated at 56 bits
    function automatic logic [TIME_W-1:0] segment_time(int unsigned seg, logic [TICK_W-1:0] t);
        logic [63:0] d, add, sum;
        d   = 64'(t - tbl_tick[seg]);
        add = (d * 64'(tbl_tempo[seg])) / 64'd480;
        sum = 64'(tbl_time[seg]) + add;
        if (sum > 64'h00FF_FFFF_FFFF_FFFF)
            sum = 64'h00FF_FFFF_FFFF_FFFF;
        return sum[TIME_W-1:0];
    endfunction

    // work out the answer of one word and update the shadow table
    function automatic tempo_ans_t tempo_predict(tempo_req_t r);
        tempo_ans_t  a;
        logic [63:0] dv, sc, tp, d, q, rm, frac, res;
        logic [31:0] st;
        int unsigned n, seg;
        a = '0;
        n = tbl_count;
        case (r.op)
            OP_APPEND:
            begin
                dv = (shadow_tpq == 0) ? 64'd1 : 64'(shadow_tpq);
                sc = (64'(r.tick) * 64'd480) / dv;
                st = (sc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sc[31:0];
                if (n >= TEMPO_ENTRIES)
                begin
                    a.status = ST_FULL;
                    full_seen++;
                end
                else if (st < tbl_tick[n-1])
                begin
                    a.status = ST_ORDER;
                    order_seen++;
                end
                else
                begin
                    tbl_time[n]  = segment_time(n - 1, st);
                    tbl_tick[n]  = st;
                    tbl_tempo[n] = (r.tempo == 0) ? 24'd1 : r.tempo;
                    tbl_count    = n + 1;
                end
            end
            OP_TICK2TIME:
            begin
                seg = 0;
                for (int i = 0; i < n; i++)
                    if (tbl_tick[i] <= r.tick)
                        seg = i;
                a.time_out = segment_time(seg, r.tick);
            end
            OP_TIME2TICK:
            begin
                seg = 0;
                for (int i = 0; i < n; i++)
                    if (tbl_time[i] <= r.time_v)
                        seg = i;
                tp   = (tbl_tempo[seg] == 0) ? 64'd1 : 64'(tbl_tempo[seg]);
                d    = 64'(r.time_v) - 64'(tbl_time[seg]);
                q    = d / tp;
                rm   = d % tp;
                frac = (rm * 64'd480) / tp;
                if (q > 64'hFFFF_FFFF)
                    res = 64'hFFFF_FFFF;
                else
                begin
                    res = q * 64'd480 + frac + 64'(tbl_tick[seg]);
                    if (res > 64'hFFFF_FFFF)
                        res = 64'hFFFF_FFFF;
                end
                a.tick_out = res[31:0];
            end
            default:
                table_reset();
        endcase
        return a;
    endfunction

    // send one word; entered and left at a rising edge
    task automatic send_word(tempo_req_t r);
        int unsigned gap;
        bit hs;
        gap = $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.opcode   <= r.op;
        in_ch.tick     <= r.tick;
        in_ch.tempo_us <= r.tempo;
        in_ch.time_us  <= r.time_v;
        do
        begin
            @(negedge clk);
            hs = in_ch.ready;
            @(posedge clk);
        end
        while (!hs);
        answer_q = {answer_q, tempo_predict(r)};
        words_sent++;
        if (r.op == OP_CLEAR)
            file_pos = '0;
    endtask

    function automatic tempo_req_t mk(op_t op, logic [31:0] t, logic [23:0] tp, logic [55:0] tv);
        tempo_req_t r;
        r.op = op; r.tick = t; r.tempo = tp; r.time_v = tv;
        return r;
    endfunction

    // wait until the block is idle, then write the resolution register
    task automatic write_tpq(logic [TPQ_W-1:0] v);
        in_ch.valid <= 1'b0;
        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_TPQ;
        pwdata  <= 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_tpq = v;
        @(posedge clk);
    endtask

    // answer side: random hold-off per word, one long hold on request
    initial
    begin
        int unsigned w;
        bit hs;
        tempo_ans_t got, exp_a;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            w = $urandom_range(0, 8);
            if (long_hold_req)
            begin
                w = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (w > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
            begin
                @(negedge clk);
                hs  = out_ch.valid;
                got = {out_ch.time_out_us, out_ch.tick_out, out_ch.status};
                @(posedge clk);
            end
            while (!hs);
            answers_seen++;
            if (answer_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected answer word: time %0h tick %0h status %0d",
                             got.time_out, got.tick_out, got.status);
            end
            else
            begin
                exp_a = answer_q.pop_front();
                if (got.time_out !== exp_a.time_out || got.tick_out !== exp_a.tick_out ||
                    got.status !== exp_a.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"answer mismatch: time exp %0h got %0h, ",
                                  "tick exp %0h got %0h, status exp %0d got %0d"},
                                 exp_a.time_out, got.time_out, exp_a.tick_out, got.tick_out,
                                 exp_a.status, got.status);
                end
            end
        end
    end

    // watchdog on cycles with no word accepted on either side and no APB access
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        forever
        begin
            @(negedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired, %0d answers outstanding", answer_q.size());
                $display("midi_tempo_map_converter_tb NOT OK");
                $finish;
            end
        end
    end

    // extremes, every operation and the named corner cases
    task automatic test_directed();
        send_word(mk(OP_TICK2TIME, 32'd0, 24'd0, 56'd0));
        send_word(mk(OP_TICK2TIME, 32'hFFFF_FFFF, 24'hFF_FFFF, 56'hFF_FFFF_FFFF_FFFF));
        send_word(mk(OP_TIME2TICK, 32'd0, 24'd0, 56'd0));
        send_word(mk(OP_TIME2TICK, 32'd0, 24'd0, 56'hFF_FFFF_FFFF_FFFF));
        send_word(mk(OP_APPEND, 32'd960, 24'd0, 56'd0));          // zero tempo stored as one
        send_word(mk(OP_TIME2TICK, 32'd0, 24'd0, 56'hFF_FFFF_FFFF_FFFF)); // tick saturation
        send_word(mk(OP_APPEND, 32'd960, 24'd250000, 56'd0));     // equal tick accepted
        send_word(mk(OP_APPEND, 32'd100, 24'd300000, 56'd0));     // out of order
        send_word(mk(OP_TICK2TIME, 32'd960, 24'd0, 56'd0));       // last of equal starts
        send_word(mk(OP_TIME2TICK, 32'd0, 24'd0, 56'd1000000));
        send_word(mk(OP_APPEND, 32'hFFFF_FFFF, 24'hFF_FFFF, 56'd0));
        send_word(mk(OP_TICK2TIME, 32'hFFFF_FFFF, 24'd0, 56'd0));
        send_word(mk(OP_TIME2TICK, 32'd0, 24'd0, 56'hFF_FFFF_FFFF_FFFF));
        send_word(mk(OP_CLEAR, 32'hFFFF_FFFF, 24'hFF_FFFF, 56'hFF_FFFF_FFFF_FFFF));
        send_word(mk(OP_TICK2TIME, 32'd480, 24'd0, 56'd0));
        // fill the table, then two more appends hit the full case
        for (int i = 1; i <= TEMPO_ENTRIES + 1; i++)
            send_word(mk(OP_APPEND, 32'(i * 240), 24'(i * 1000 + 1), 56'd0));
        send_word(mk(OP_APPEND, 32'd0, 24'd1, 56'd0));            // full, checked before order
        send_word(mk(OP_TIME2TICK, 32'd0, 24'd0, 56'hFF_FFFF_FFFF_FFFF));
        send_word(mk(OP_TICK2TIME, 32'hFFFF_FFFF, 24'd0, 56'd0));
        send_word(mk(OP_CLEAR, 32'd0, 24'd0, 56'd0));
    endtask

    // random word, mostly ordered appends and queries near table entries
    function automatic tempo_req_t random_word();
        tempo_req_t r;
        int unsigned k, seg;
        r = mk(OP_CLEAR, $urandom(), 24'($urandom()), {24'($urandom()), 32'($urandom())});
        k = $urandom_range(0, 99);
        seg = $urandom_range(0, tbl_count - 1);
        if (k < 2)
            r.op = OP_CLEAR;
        else if (k < 40)
        begin
            r.op = OP_APPEND;
            if (k < 35)
            begin
                file_pos = file_pos + (($urandom_range(0, 7) == 0) ? $urandom() >> 6
                                                                   : $urandom_range(0, 3000));
                r.tick = file_pos;
            end
            else if (k < 38)
                r.tick = file_pos - $urandom_range(1, 500);
            if ($urandom_range(0, 15) != 0)
                r.tempo = 24'($urandom_range(1, 2000000));
        end
        else if (k < 70)
        begin
            r.op = OP_TICK2TIME;
            if (k < 66)
                r.tick = tbl_tick[seg] + $urandom_range(0, 5000) - 32'd50;
        end
        else
        begin
            r.op = OP_TIME2TICK;
            if (k < 96)
                r.time_v = tbl_time[seg] + 56'($urandom_range(0, 5000000)) - 56'd100;
        end
        return r;
    endfunction

    task automatic test_random_phase(logic [TPQ_W-1:0] tpq, int unsigned count);
        write_tpq(tpq);
        send_word(mk(OP_CLEAR, 32'd0, 24'd0, 56'd0));
        for (int i = 0; i < count; i++)
            send_word(random_word());
    endtask

    // hold the answer side off while words keep coming
    task automatic test_back_pressure();
        long_hold_req = 1'b1;
        for (int i = 0; i < 30; i++)
            send_word(mk(($urandom_range(0, 1) == 1) ? OP_TICK2TIME : OP_APPEND,
                         32'(i * 100), 24'($urandom_range(1, 900000)), 56'($urandom())));
    endtask

    initial
    begin
        in_ch.valid    <= 1'b0;
        in_ch.opcode   <= OP_CLEAR;
        in_ch.tick     <= '0;
        in_ch.tempo_us <= '0;
        in_ch.time_us  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        rst_n   <= 1'b0;
        mismatches = 0; words_sent = 0; answers_seen = 0;
        full_seen = 0; order_seen = 0; file_pos = '0;
        long_hold_req = 1'b0;
        shadow_tpq = TPQ_RESET;
        table_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_back_pressure();
        test_random_phase(15'd480, 300);
        test_random_phase(15'd1, 150);
        test_random_phase(15'h7FFF, 200);
        test_random_phase(15'd0, 150);
        test_random_phase(15'd96, 200);
        test_random_phase(15'($urandom_range(1, 32767)), 200);

        in_ch.valid <= 1'b0;
        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d words sent, %0d answers checked, %0d table-full and %0d out-of-order appends",
                 words_sent, answers_seen, full_seen, order_seen);
        $display("resolutions covered: 0, 1, 96, 480, 32767 and one random; %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("midi_tempo_map_converter_tb OK");
        else
            $display("midi_tempo_map_converter_tb NOT OK");
        $finish;
    end

endmodule
